// ===== sv/swrm_pkg.sv =====
package swrm_pkg;

  localparam int OP_W     = 2;
  localparam int STAMP_W  = 32;
  localparam int WIN_W    = 16;
  localparam int CPW_W    = 5;
  localparam int RATE_W   = 8;
  localparam int MSPM_W   = 16;
  localparam int DIV_W    = CPW_W + WIN_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W   = 4;

  localparam logic [MSPM_W-1:0] MS_PER_MINUTE = 16'd60000;
  localparam logic [RATE_W-1:0] RATE_MAX      = 8'd255;
  localparam logic [WIN_W-1:0]  WINDOW_RESET  = 16'd5000;
  localparam logic [CPW_W-1:0]  CPW_RESET     = 5'd5;

  typedef enum logic [OP_W-1:0] {
    OP_EVENT = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 1'b0,
    CFG_CPW    = 1'b1
  } cfg_idx_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

endpackage

// ===== sv/swrm_in_if.sv =====
interface swrm_in_if;
  import swrm_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [STAMP_W-1:0] now_ms;

  modport source (output valid, output opcode, output now_ms, input ready);
  modport sink   (input valid, input opcode, input now_ms, output ready);
endinterface

// ===== sv/swrm_out_if.sv =====
interface swrm_out_if;
  import swrm_pkg::*;

  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] current_rate;
  logic [RATE_W-1:0] peak_rate;

  modport source (output valid, output current_rate, output peak_rate, input ready);
  modport sink   (input valid, input current_rate, input peak_rate, output ready);
endinterface

// ===== sv/swrm_ram.sv =====
module swrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/swrm_sub.sv =====
module swrm_sub #(
  parameter int WIDTH = 32
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  output logic [WIDTH-1:0] diff_o,
  output logic             borrow_o
);

  // The borrow out doubles as the unsigned a < b flag for the divider.
  assign {borrow_o, diff_o} = {1'b0, a_i} - {1'b0, b_i};

endmodule

// ===== sv/sliding_window_rate_meter.sv =====
// Sliding-window event rate meter. Event items store their timestamp in a ring of the last
// HISTORY_DEPTH stamps; tick items count the stamps younger than the configured window and turn
// the count into words per minute, count*60000/(events_per_word*window), saturated at 255, or
// let the rate decay by one when nothing is recent; clear items empty the ring and zero the rate
// but keep the peak. Every item returns one result with the current and peak rates. A tick
// makes one ring read per stored stamp through the single read port of the stamp memory, then
// runs a restoring divider of nine steps that shares one subtractor with the age compare. The
// input is ready whenever the sequencer is idle, even while an earlier result waits to be taken.
module sliding_window_rate_meter #(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [swrm_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [swrm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  swrm_in_if.sink                             in_if,
  swrm_out_if.source                          out_if
);
  import swrm_pkg::*;

  localparam int AW  = $clog2(HISTORY_DEPTH);
  localparam int CW  = $clog2(HISTORY_DEPTH + 1);
  localparam int NW  = CW + MSPM_W;
  localparam int DSW = DIV_W + RATE_W;
  localparam int UW  = (NW > STAMP_W) ? NW : STAMP_W;

  state_t             state_r, state_nxt;
  logic [WIN_W-1:0]   window_r;
  logic [CPW_W-1:0]   cpw_r;
  logic [AW-1:0]      wslot_r, wslot_nxt;
  logic [CW-1:0]      stored_r, stored_nxt;
  logic [RATE_W-1:0]  rate_now_r, rate_now_nxt;
  logic [RATE_W-1:0]  rate_peak_r, rate_peak_nxt;
  logic [STAMP_W-1:0] now_r, now_nxt;
  logic [AW-1:0]      scan_idx_r, scan_idx_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [CW-1:0]      recent_r, recent_nxt;
  logic [NW-1:0]      rem_r, rem_nxt;
  logic [DSW-1:0]     dsh_r, dsh_nxt;
  logic [RATE_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [RATE_W-1:0]  out_cur_r, out_cur_nxt;
  logic [RATE_W-1:0]  out_peak_r, out_peak_nxt;

  logic               in_xfer;
  logic               ram_we;
  logic [STAMP_W-1:0] ram_rdata;
  logic [UW-1:0]      sub_a, sub_b, sub_diff;
  logic               sub_borrow;
  logic [STAMP_W-1:0] age;
  logic               hit;
  logic               out_free;
  logic [DIV_W-1:0]   divisor;
  logic [RATE_W-1:0]  peak_new;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;
  assign ram_we      = in_xfer && (in_if.opcode == OP_EVENT);
  assign out_free    = !out_vld_r || out_if.ready;

  swrm_ram #(.WIDTH(STAMP_W), .DEPTH(HISTORY_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wslot_r),
    .wdata (in_if.now_ms),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  // One subtractor: stamp age during the scan, trial subtraction during the division.
  assign sub_a = (state_r == ST_DIV) ? UW'(rem_r) : UW'(now_r);
  assign sub_b = (state_r == ST_DIV) ? UW'(dsh_r) : UW'(ram_rdata);

  swrm_sub #(.WIDTH(UW)) u_sub (
    .a_i      (sub_a),
    .b_i      (sub_b),
    .diff_o   (sub_diff),
    .borrow_o (sub_borrow)
  );

  assign age      = sub_diff[STAMP_W-1:0];
  assign hit      = (age[STAMP_W-1:WIN_W] == '0) && (age[WIN_W-1:0] < window_r);
  assign divisor  = DIV_W'(cpw_r) * DIV_W'(window_r);
  assign peak_new = (rate_now_r > rate_peak_r) ? rate_now_r : rate_peak_r;

  always_comb begin
    state_nxt     = state_r;
    wslot_nxt     = wslot_r;
    stored_nxt    = stored_r;
    rate_now_nxt  = rate_now_r;
    rate_peak_nxt = rate_peak_r;
    now_nxt       = now_r;
    scan_idx_nxt  = scan_idx_r;
    rd_vld_nxt    = 1'b0;
    recent_nxt    = recent_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    out_vld_nxt   = out_vld_r && !out_if.ready;
    out_cur_nxt   = out_cur_r;
    out_peak_nxt  = out_peak_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          now_nxt      = in_if.now_ms;
          scan_idx_nxt = '0;
          recent_nxt   = '0;
          state_nxt    = ST_FIN;
          case (in_if.opcode)
            OP_EVENT: begin
              wslot_nxt = (wslot_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wslot_r + 1'b1;
              if (stored_r != CW'(HISTORY_DEPTH)) begin
                stored_nxt = stored_r + 1'b1;
              end
            end
            OP_TICK: begin
              state_nxt = (stored_r == '0) ? ST_MUL : ST_SCAN;
            end
            OP_CLEAR: begin
              stored_nxt   = '0;
              wslot_nxt    = '0;
              rate_now_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN, ST_DRAIN: begin
        if (rd_vld_r && hit) begin
          recent_nxt = recent_r + 1'b1;
        end
        if (state_r == ST_SCAN) begin
          rd_vld_nxt = 1'b1;
          if (CW'(scan_idx_r) == stored_r - 1'b1) begin
            state_nxt = ST_DRAIN;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        rem_nxt  = NW'(recent_r) * NW'(MS_PER_MINUTE);
        dsh_nxt  = {divisor, {RATE_W{1'b0}}};
        quo_nxt  = '0;
        step_nxt = STEP_W'(RATE_W);
        if (recent_r == '0) begin
          if (rate_now_r != '0) begin
            rate_now_nxt = rate_now_r - 1'b1;
          end
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        dsh_nxt  = dsh_r >> 1;
        step_nxt = step_r - 1'b1;
        if (step_r == STEP_W'(RATE_W)) begin
          // A quotient of 256 or more saturates; a zero divisor lands here too.
          if (!sub_borrow) begin
            rate_now_nxt = RATE_MAX;
            state_nxt    = ST_FIN;
          end
        end else begin
          if (!sub_borrow) begin
            rem_nxt = sub_diff[NW-1:0];
          end
          quo_nxt = {quo_r[RATE_W-2:0], !sub_borrow};
          if (step_r == '0) begin
            rate_now_nxt = {quo_r[RATE_W-2:0], !sub_borrow};
            state_nxt    = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          rate_peak_nxt = peak_new;
          out_vld_nxt   = 1'b1;
          out_cur_nxt   = rate_now_r;
          out_peak_nxt  = peak_new;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= WINDOW_RESET;
      cpw_r       <= CPW_RESET;
      wslot_r     <= '0;
      stored_r    <= '0;
      rate_now_r  <= '0;
      rate_peak_r <= '0;
      rd_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wslot_r     <= wslot_nxt;
      stored_r    <= stored_nxt;
      rate_now_r  <= rate_now_nxt;
      rate_peak_r <= rate_peak_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_vld_r   <= out_vld_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_WINDOW: window_r <= cfg_wdata[WIN_W-1:0];
          CFG_CPW:    cpw_r    <= cfg_wdata[CPW_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    scan_idx_r <= scan_idx_nxt;
    recent_r   <= recent_nxt;
    rem_r      <= rem_nxt;
    dsh_r      <= dsh_nxt;
    quo_r      <= quo_nxt;
    step_r     <= step_nxt;
    out_cur_r  <= out_cur_nxt;
    out_peak_r <= out_peak_nxt;
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.current_rate = out_cur_r;
  assign out_if.peak_rate    = out_peak_r;

`ifndef SYNTHESIS
  a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= CW'(HISTORY_DEPTH))
    else $error("stored stamp count exceeds ring depth");

  a_recent_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (recent_r <= stored_r))
    else $error("recent count exceeds stored stamps");

  a_peak_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (rate_now_r <= rate_peak_r))
    else $error("current rate above peak while idle");

  a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_free) |=> (state_r == ST_IDLE && out_vld_r))
    else $error("finished item did not reach the output register");
`endif

endmodule
